FILE: rtl/isst_pkg.sv
// Shared types and constants for the interval set subtract/intersect block.
`default_nettype none
package isst_pkg;
  localparam int MaskDepthDef = 256;
  localparam int MaxPiecesDef = 64;
  localparam int ChromW = 8;
  localparam int PosW = 32;
  localparam int EntryW = ChromW + 2 * PosW;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic take;
    logic start;
    logic skip_adv;
    logic walk_adv;
    logic cur_adv;
    logic walk_piece;
    logic tail_piece;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  q_bad;
    logic  ptr_end;
    logic  skip_hit;
    logic  idx_end;
    logic  walk_stop;
    logic  walk_pass;
    logic  has_piece;
    logic  walk_done;
    logic  can_produce;
    logic  out_free;
    logic  mode;
  } stat_t;
endpackage
`default_nettype wire

FILE: rtl/isst_ram.sv
// Generic single-write, registered-read RAM.
`default_nettype none
module isst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata_r
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/isst_ctrl.sv
// Controller state machine: skip scan, mask walk, piece emission.
`default_nettype none
module isst_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire isst_pkg::stat_t stat,
  output isst_pkg::cmd_t      cmd
);
  import isst_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD_S  = 7'b0000010,
    S_CHK_S = 7'b0000100,
    S_RD_W  = 7'b0001000,
    S_CHK_W = 7'b0010000,
    S_END   = 7'b0100000,
    S_FINAL = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.func == FUNC_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = stat.q_bad ? S_FINAL : S_RD_S;
          end
        end
      end
      S_RD_S: begin
        state_nxt = stat.ptr_end ? S_END : S_CHK_S;
      end
      S_CHK_S: begin
        if (stat.skip_hit) begin
          cmd.skip_adv = 1'b1;
          state_nxt = S_RD_S;
        end else begin
          state_nxt = S_CHK_W;
        end
      end
      S_RD_W: begin
        state_nxt = S_CHK_W;
      end
      S_CHK_W: begin
        priority if (stat.walk_stop) begin
          state_nxt = S_END;
        end else if (stat.walk_pass) begin
          cmd.walk_adv = 1'b1;
          state_nxt = stat.idx_end ? S_END : S_RD_W;
        end else if (!stat.has_piece || stat.can_produce) begin
          cmd.walk_piece = stat.has_piece;
          if (stat.walk_done) begin
            state_nxt = S_FINAL;
          end else begin
            cmd.cur_adv = 1'b1;
            cmd.walk_adv = 1'b1;
            state_nxt = stat.idx_end ? S_END : S_RD_W;
          end
        end
      end
      S_END: begin
        if (!stat.mode) begin
          if (stat.can_produce) begin
            cmd.tail_piece = 1'b1;
            state_nxt = S_FINAL;
          end
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/isst_dp.sv
// Datapath: mask store, scan pointer, cursor, pending piece and output register.
`default_nettype none
module isst_dp #(
  parameter int MaskDepth = isst_pkg::MaskDepthDef,
  parameter int MaxPieces = isst_pkg::MaxPiecesDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_data,
  input  wire logic [1:0]                   in_func,
  input  wire logic [isst_pkg::ChromW-1:0]  in_chromosome,
  input  wire logic [isst_pkg::PosW-1:0]    in_start_pos,
  input  wire logic [isst_pkg::PosW-1:0]    in_stop_pos,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [isst_pkg::ChromW-1:0]       out_piece_chromosome,
  output logic [isst_pkg::PosW-1:0]         out_piece_start,
  output logic [isst_pkg::PosW-1:0]         out_piece_stop,
  output logic                              out_none_left,
  output logic                              out_last,
  output logic                              out_truncated,
  output logic                              out_mask_overflow,
  input  wire isst_pkg::cmd_t               cmd,
  output isst_pkg::stat_t                   stat
);
  import isst_pkg::*;

  localparam int CntW = $clog2(MaskDepth + 1);
  localparam int AddrW = (MaskDepth > 1) ? $clog2(MaskDepth) : 1;
  localparam int PcW = $clog2(MaxPieces + 1);

  logic              mode_r;
  logic [CntW-1:0]   cnt_r, scan_r, idx_r;
  logic              ovf_r;
  logic [ChromW-1:0] qchr_r;
  logic [PosW-1:0]   qs_r, qe_r, cur_r;
  logic [PcW-1:0]    n_r;
  logic              drop_r, pend_v_r;
  logic [PosW-1:0]   pend_s_r, pend_e_r;
  logic              ov_r;
  logic [ChromW-1:0] o_chr_r;
  logic [PosW-1:0]   o_s_r, o_e_r;
  logic              o_none_r, o_last_r, o_trunc_r, o_ovf_r;

  logic [EntryW-1:0] rd_data;
  logic [ChromW-1:0] mchr;
  logic [PosW-1:0]   ms, me, ps, pe;
  logic              do_load, produce, room, push_pend;

  assign mchr = rd_data[EntryW-1 -: ChromW];
  assign ms = rd_data[2*PosW-1:PosW];
  assign me = rd_data[PosW-1:0];
  assign do_load = cmd.take && (in_func == FUNC_LOAD) && (in_stop_pos >= in_start_pos) &&
                   (cnt_r < CntW'(MaskDepth));

  isst_ram #(.Width(EntryW), .Depth(MaskDepth)) u_ram (
    .clk    (clk),
    .we     (do_load),
    .waddr  (cnt_r[AddrW-1:0]),
    .wdata  ({in_chromosome, in_start_pos, in_stop_pos}),
    .raddr  (idx_r[AddrW-1:0]),
    .rdata_r(rd_data)
  );

  always_comb begin
    if (cmd.tail_piece) begin
      ps = cur_r;
      pe = qe_r;
    end else if (!mode_r) begin
      ps = cur_r;
      pe = ms - PosW'(1);
    end else begin
      ps = (ms > cur_r) ? ms : cur_r;
      pe = (me < qe_r) ? me : qe_r;
    end
  end

  assign produce = cmd.walk_piece || cmd.tail_piece;
  assign room = (n_r < PcW'(MaxPieces));
  assign push_pend = produce && room && pend_v_r;

  always_comb begin
    stat.func = func_t'(in_func);
    stat.q_bad = in_stop_pos < in_start_pos;
    stat.ptr_end = scan_r >= cnt_r;
    stat.skip_hit = (mchr < qchr_r) || ((mchr == qchr_r) && (me < qs_r));
    stat.idx_end = ({1'b0, idx_r} + (CntW+1)'(1)) >= {1'b0, cnt_r};
    stat.walk_stop = (mchr != qchr_r) || (ms > qe_r);
    stat.walk_pass = me < cur_r;
    stat.has_piece = mode_r || (ms > cur_r);
    stat.walk_done = me >= qe_r;
    stat.out_free = !ov_r || out_ready;
    stat.can_produce = !room || !pend_v_r || stat.out_free;
    stat.mode = mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cnt_r <= '0;
      scan_r <= '0;
      ovf_r <= 1'b0;
      ov_r <= 1'b0;
      pend_v_r <= 1'b0;
      n_r <= '0;
      drop_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      if (cmd.take) begin
        if (in_func == FUNC_LOAD && in_stop_pos >= in_start_pos) begin
          if (do_load) begin
            cnt_r <= cnt_r + CntW'(1);
          end else begin
            ovf_r <= 1'b1;
          end
        end
        if (in_func == FUNC_CLEAR) begin
          cnt_r <= '0;
          scan_r <= '0;
          ovf_r <= 1'b0;
        end
      end
      if (cmd.start) begin
        pend_v_r <= 1'b0;
        n_r <= '0;
        drop_r <= 1'b0;
      end
      if (cmd.skip_adv) begin
        scan_r <= scan_r + CntW'(1);
      end
      if (produce) begin
        if (room) begin
          pend_v_r <= 1'b1;
          n_r <= n_r + PcW'(1);
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (push_pend || cmd.emit_final) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      qchr_r <= in_chromosome;
      qs_r <= in_start_pos;
      qe_r <= in_stop_pos;
    end
    if (cmd.start) begin
      cur_r <= in_start_pos;
      idx_r <= scan_r;
    end
    if (cmd.skip_adv) begin
      idx_r <= scan_r + CntW'(1);
    end
    if (cmd.walk_adv) begin
      idx_r <= idx_r + CntW'(1);
    end
    if (cmd.cur_adv) begin
      cur_r <= me + PosW'(1);
    end
    if (produce && room) begin
      pend_s_r <= ps;
      pend_e_r <= pe;
    end
    if (push_pend) begin
      o_chr_r <= qchr_r;
      o_s_r <= pend_s_r;
      o_e_r <= pend_e_r;
      o_none_r <= 1'b0;
      o_last_r <= 1'b0;
      o_trunc_r <= 1'b0;
      o_ovf_r <= ovf_r;
    end else if (cmd.emit_final) begin
      o_chr_r <= pend_v_r ? qchr_r : '0;
      o_s_r <= pend_v_r ? pend_s_r : '0;
      o_e_r <= pend_v_r ? pend_e_r : '0;
      o_none_r <= !pend_v_r;
      o_last_r <= 1'b1;
      o_trunc_r <= pend_v_r && drop_r;
      o_ovf_r <= ovf_r;
    end
  end

  assign out_valid = ov_r;
  assign out_piece_chromosome = o_chr_r;
  assign out_piece_start = o_s_r;
  assign out_piece_stop = o_e_r;
  assign out_none_left = o_none_r;
  assign out_last = o_last_r;
  assign out_truncated = o_trunc_r;
  assign out_mask_overflow = o_ovf_r;
endmodule
`default_nettype wire

FILE: rtl/interval_set_subtract_intersect.sv
// Top level: sorted interval set subtract/intersect against a stored mask set.
// Load, clear and ignored items are taken in the idle state; a query with stop below
// start goes straight to its final result. Other queries read each skipped and each
// walked mask in turn and can stall on out_ready.
// The last result of a query is valid the cycle after it ends, as the next item is taken.
// Synchronous active-low reset clears mode, mask count, scan pointer, overflow flag.
`default_nettype none
module interval_set_subtract_intersect #(
  parameter int MaskDepth = isst_pkg::MaskDepthDef,
  parameter int MaxPieces = isst_pkg::MaxPiecesDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_func,
  input  wire logic [isst_pkg::ChromW-1:0]  in_chromosome,
  input  wire logic [isst_pkg::PosW-1:0]    in_start_pos,
  input  wire logic [isst_pkg::PosW-1:0]    in_stop_pos,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [isst_pkg::ChromW-1:0]       out_piece_chromosome,
  output logic [isst_pkg::PosW-1:0]         out_piece_start,
  output logic [isst_pkg::PosW-1:0]         out_piece_stop,
  output logic                              out_none_left,
  output logic                              out_last,
  output logic                              out_truncated,
  output logic                              out_mask_overflow
);
  import isst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  isst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  isst_dp #(.MaskDepth(MaskDepth), .MaxPieces(MaxPieces)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_data            (cfg_data),
    .in_func             (in_func),
    .in_chromosome       (in_chromosome),
    .in_start_pos        (in_start_pos),
    .in_stop_pos         (in_stop_pos),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_piece_chromosome(out_piece_chromosome),
    .out_piece_start     (out_piece_start),
    .out_piece_stop      (out_piece_stop),
    .out_none_left       (out_none_left),
    .out_last            (out_last),
    .out_truncated       (out_truncated),
    .out_mask_overflow   (out_mask_overflow),
    .cmd                 (cmd),
    .stat                (stat)
  );

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_QUERY |=> !in_ready)
    else $error("query item did not hold off input");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_left |-> out_last)
    else $error("none_left result not marked last");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_last && !out_none_left)
    else $error("truncated flag on a non-final result");
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for the interval set subtract/intersect block: scoreboard class and stimulus.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import isst_pkg::*;

  typedef struct packed {
    logic [7:0]  chrom;
    logic [31:0] pstart;
    logic [31:0] pstop;
    logic        none_left;
    logic        last;
    logic        trunc;
    logic        ovf;
  } piece_t;

  class piece_board;
    logic [31:0] m_lo[256];
    logic [31:0] m_hi[256];
    logic [7:0]  m_chr[256];
    int unsigned n_mask;
    int unsigned ptr;
    bit          ovf;
    bit          mode;
    piece_t      pending[$];
    int          n_bad;
    int          n_seen;
    int          n_query;

    function void clear_state();
      n_mask = 0;
      ptr = 0;
      ovf = 0;
      mode = 0;
    endfunction

    function void push_piece(logic [7:0] c, logic [31:0] s, logic [31:0] e, bit nl,
                             ref int cnt, ref bit dropped);
      piece_t p;
      if (cnt >= 64) begin
        dropped = 1;
        return;
      end
      p.chrom = c;
      p.pstart = s;
      p.pstop = e;
      p.none_left = nl;
      p.last = 0;
      p.trunc = 0;
      p.ovf = ovf;
      pending.push_back(p);
      cnt++;
    endfunction

    function void note_item(func_t f, logic [7:0] c, logic [31:0] qs, logic [31:0] qe);
      int cnt;
      bit dropped;
      bit done;
      logic [31:0] cur;
      int unsigned i;
      piece_t p;
      cnt = 0;
      dropped = 0;
      done = 0;
      case (f)
        FUNC_LOAD: begin
          if (qe < qs) return;
          if (n_mask >= 256) begin
            ovf = 1;
            return;
          end
          m_lo[n_mask] = qs;
          m_hi[n_mask] = qe;
          m_chr[n_mask] = c;
          n_mask++;
        end
        FUNC_CLEAR: begin
          n_mask = 0;
          ptr = 0;
          ovf = 0;
        end
        FUNC_QUERY: begin
          n_query++;
          if (qe < qs) begin
            push_piece(0, 0, 0, 1, cnt, dropped);
          end else begin
            while (ptr < n_mask && (m_chr[ptr] < c || (m_chr[ptr] == c && m_hi[ptr] < qs)))
              ptr++;
            cur = qs;
            for (i = ptr; i < n_mask && !done; i++) begin
              if (m_chr[i] != c || m_lo[i] > qe) break;
              if (m_hi[i] < cur) continue;
              if (!mode) begin
                if (m_lo[i] > cur) push_piece(c, cur, m_lo[i] - 1, 0, cnt, dropped);
              end else begin
                push_piece(c, (m_lo[i] > cur) ? m_lo[i] : cur,
                           (m_hi[i] < qe) ? m_hi[i] : qe, 0, cnt, dropped);
              end
              if (m_hi[i] >= qe) done = 1;
              else cur = m_hi[i] + 1;
            end
            if (!mode && !done) push_piece(c, cur, qe, 0, cnt, dropped);
            if (cnt == 0) push_piece(0, 0, 0, 1, cnt, dropped);
          end
          p = pending.pop_back();
          p.last = 1;
          p.trunc = dropped;
          pending.push_back(p);
        end
        default: ;
      endcase
    endfunction

    function void check_piece(piece_t got);
      piece_t want;
      n_seen++;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected piece %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("piece mismatch: expected chr %0d %0d..%0d nl %b last %b tr %b ov %b",
                   want.chrom, want.pstart, want.pstop, want.none_left, want.last,
                   want.trunc, want.ovf);
          $display("                got      chr %0d %0d..%0d nl %b last %b tr %b ov %b",
                   got.chrom, got.pstart, got.pstop, got.none_left, got.last,
                   got.trunc, got.ovf);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0, cfg_data = 0, cfg_ready;
  logic in_valid = 0, in_ready;
  logic [1:0] in_func = 0;
  logic [7:0] in_chromosome = 0;
  logic [31:0] in_start_pos = 0, in_stop_pos = 0;
  logic out_valid, out_ready = 0;
  logic [7:0] out_piece_chromosome;
  logic [31:0] out_piece_start, out_piece_stop;
  logic out_none_left, out_last, out_truncated, out_mask_overflow;

  piece_board board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int n_items = 0;
  logic [7:0] q_chr;
  logic [31:0] q_pos;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  interval_set_subtract_intersect dut (.*);

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_req && hold_cnt < 300) begin
      hold_cnt <= hold_cnt + 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_piece({out_piece_chromosome, out_piece_start, out_piece_stop,
                         out_none_left, out_last, out_truncated, out_mask_overflow});
  end

  task automatic send_item(func_t f, logic [7:0] c, logic [31:0] s, logic [31:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_func <= f;
    in_chromosome <= c;
    in_start_pos <= s;
    in_stop_pos <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(f, c, s, e);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_mode(bit m);
    drain();
    cfg_valid <= 1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.mode = m;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // sorted mask set: n masks on a few chromosomes, random gaps and widths
  task automatic load_masks(int n, logic [31:0] step);
    logic [7:0] c;
    logic [31:0] p;
    logic [31:0] w;
    c = $urandom_range(3);
    p = $urandom_range(20);
    send_item(FUNC_CLEAR, 0, 0, 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        c = c + 1;
        p = $urandom_range(20);
      end
      w = $urandom_range(step);
      send_item(FUNC_LOAD, c, p, p + w);
      p = p + w + 2 + $urandom_range(step);
    end
  endtask

  task automatic run_queries(int n, logic [31:0] step);
    q_chr = 0;
    q_pos = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) begin
        q_chr = q_chr + 1;
        q_pos = 0;
      end
      q_pos = q_pos + $urandom_range(step);
      case ($urandom_range(19))
        0: send_item(func_t'($urandom_range(3)), $urandom, $urandom, $urandom);
        1: send_item(FUNC_QUERY, q_chr, q_pos + 5, q_pos);
        default: send_item(FUNC_QUERY, q_chr, q_pos, q_pos + $urandom_range(4 * step));
      endcase
    end
  endtask

  initial begin
    board = new();
    board.clear_state();
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed
    send_item(FUNC_QUERY, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_mode(1);
    send_item(FUNC_QUERY, 0, 0, 32'hFFFF_FFFF);
    send_item(FUNC_LOAD, 1, 10, 5);
    send_item(FUNC_LOAD, 1, 10, 20);
    send_item(FUNC_LOAD, 1, 30, 40);
    send_item(FUNC_LOAD, 8'hFF, 0, 32'hFFFF_FFFF);
    send_item(FUNC_NONE, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(FUNC_QUERY, 0, 0, 100);
    send_item(FUNC_QUERY, 1, 0, 100);
    send_item(FUNC_QUERY, 1, 15, 35);
    send_item(FUNC_QUERY, 1, 50, 40);
    send_item(FUNC_QUERY, 8'hFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    write_mode(0);
    send_item(FUNC_QUERY, 1, 0, 100);
    send_item(FUNC_QUERY, 1, 12, 18);
    send_item(FUNC_QUERY, 8'hFF, 0, 32'hFFFF_FFFF);
    send_item(FUNC_CLEAR, 0, 0, 0);
    // fill past capacity, then a query in each mode that yields more than the piece limit
    for (int i = 0; i < 258; i++) send_item(FUNC_LOAD, 2, 4 * i, 4 * i + 1);
    send_item(FUNC_QUERY, 2, 0, 32'hFFFF_FFFF);
    write_mode(1);
    send_item(FUNC_QUERY, 2, 0, 32'hFFFF_FFFF);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 54 : 0;
      recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 30 : 0;
      write_mode(ph[0]);
      load_masks(6 + $urandom_range(6), 50);
      if (ph == 2) hold_req = 1;
      run_queries(10, 40);
      drain();
    end

    $display("covered %0d items, %0d queries, %0d pieces checked, both modes",
             n_items, board.n_query, board.n_seen);
    if (board.n_bad == 0 && board.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
